[design/tree_barrier_arrival_top_macros.svh]
// ---------------------------------------------------------------------------
// Tree barrier arrival: assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, reset on rst_ni.
// ---------------------------------------------------------------------------
`ifndef TREE_BARRIER_ARRIVAL_TOP_MACROS_SVH
`define TREE_BARRIER_ARRIVAL_TOP_MACROS_SVH

// ante implies cons on the same edge
`define TBA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tba assertion failed");

// cond never holds
`define TBA_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tba assertion failed");

`endif

[design/tba_pkg.sv]
// ---------------------------------------------------------------------------
// Tree barrier arrival: package
// Sizes, widths and the ticket table write request type.
// ---------------------------------------------------------------------------
package tba_pkg;

  localparam int MaxParticipants = 64;
  localparam int MaxRounds       = 6;
  localparam int NodeCount       = (MaxParticipants + 1) / 2;
  localparam int TableDepth      = NodeCount * MaxRounds;

  localparam int AddrW   = $clog2(TableDepth);
  localparam int CntW    = $clog2(NodeCount + 1);
  localparam int RemW    = $clog2(MaxParticipants + 1);
  localparam int RoundW  = $clog2(MaxRounds + 1);
  localparam int PhaseW  = 8;
  localparam int SlotInW = 5;
  localparam int PartW   = 7;

  typedef struct packed {
    logic              en;
    logic [AddrW-1:0]  addr;
    logic [PhaseW-1:0] data;
  } tba_wr_t;

endpackage

[design/tba_table.sv]
// ---------------------------------------------------------------------------
// Tree barrier arrival: ticket table
// Synchronous ticket phase memory with registered read data. Per-entry valid
// flops make unwritten entries read as zero right after reset.
// ---------------------------------------------------------------------------
module tba_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [tba_pkg::AddrW-1:0]     rd_addr_i,
  output logic [tba_pkg::PhaseW-1:0]    rd_data_o,
  input  tba_pkg::tba_wr_t              wr_i
);

  logic [tba_pkg::PhaseW-1:0]     mem [tba_pkg::TableDepth];
  logic [tba_pkg::TableDepth-1:0] vld_q;
  logic [tba_pkg::PhaseW-1:0]     rd_data_q;
  logic                           rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

[design/tree_barrier_arrival_top.sv]
// ---------------------------------------------------------------------------
// Tree barrier arrival: top level
// Each probe is a table read (StEval), then a check and write back (StChk).
// An arrival goes to StFin from StChk on a claim or an exhausted round, and
// from StEval when it completes or hits the round limit; input is ready the
// cycle after StFin loads its result beat. A result beat waiting
// downstream holds the next walk at its end. Reset clears control and table
// valid flops (table reads zero), no clear pass; participants resets to 64.
// ---------------------------------------------------------------------------
module tree_barrier_arrival_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,     // participants
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [4:0] start_slot, [12:5] phase, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] completed, [1] overrun, pad
);

  `include "tree_barrier_arrival_top_macros.svh"

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StEval = 2'd1;
  localparam logic [1:0] StChk  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]                    st_q, st_d;
  logic [tba_pkg::PartW-1:0]     part_q;
  logic [tba_pkg::RemW-1:0]      rem_q, rem_d;
  logic [tba_pkg::CntW-1:0]      slot_q, slot_d;
  logic [tba_pkg::CntW-1:0]      probe_q, probe_d;
  logic [tba_pkg::RoundW-1:0]    round_q, round_d;
  logic [tba_pkg::PhaseW-1:0]    phase_q, phase_d;
  logic                          res_cmp_q, res_cmp_d;
  logic                          res_ovr_q, res_ovr_d;
  logic                          out_vld_q, out_vld_d;
  logic                          out_cmp_q, out_cmp_d;
  logic                          out_ovr_q, out_ovr_d;

  logic [tba_pkg::SlotInW-1:0]   in_slot;
  logic [tba_pkg::PhaseW-1:0]    in_phase;
  logic [tba_pkg::RemW-1:0]      rem0;
  logic [tba_pkg::CntW-1:0]      end0;
  logic [tba_pkg::CntW-1:0]      round_nodes;
  logic [tba_pkg::PhaseW-1:0]    claim_ph, done_ph, tkt;
  logic [tba_pkg::AddrW-1:0]     addr;
  logic                          odd_last, rd_en;
  tba_pkg::tba_wr_t              wr;

  assign in_slot  = s_axis_tdata[4:0];
  assign in_phase = s_axis_tdata[12:5];

  assign rem0 = (32'(part_q) > 32'(tba_pkg::MaxParticipants)) ?
                tba_pkg::RemW'(tba_pkg::MaxParticipants) : tba_pkg::RemW'(part_q);
  assign end0        = tba_pkg::CntW'((32'(rem0) + 32'd1) >> 1);
  assign round_nodes = tba_pkg::CntW'((32'(rem_q) + 32'd1) >> 1);

  assign claim_ph = phase_q + tba_pkg::PhaseW'(1);
  assign done_ph  = phase_q + tba_pkg::PhaseW'(2);
  assign addr = tba_pkg::AddrW'(32'(slot_q) * tba_pkg::MaxRounds + 32'(round_q));
  assign odd_last = (32'(slot_q) + 32'd1 == 32'(round_nodes)) && rem_q[0];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_ovr_q, out_cmp_q};

  tba_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr),
    .rd_data_o (tkt),
    .wr_i      (wr)
  );

  always_comb begin
    st_d      = st_q;
    rem_d     = rem_q;
    slot_d    = slot_q;
    probe_d   = probe_q;
    round_d   = round_q;
    phase_d   = phase_q;
    res_cmp_d = res_cmp_q;
    res_ovr_d = res_ovr_q;
    out_vld_d = out_vld_q & ~m_axis_tready;
    out_cmp_d = out_cmp_q;
    out_ovr_d = out_ovr_q;
    rd_en     = 1'b0;
    wr.en     = 1'b0;
    wr.addr   = addr;
    wr.data   = done_ph;

    case (st_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          rem_d     = rem0;
          slot_d    = ((tba_pkg::CntW + 5)'(in_slot) < (tba_pkg::CntW + 5)'(end0)) ?
                      tba_pkg::CntW'(in_slot) : '0;
          probe_d   = '0;
          round_d   = '0;
          phase_d   = in_phase;
          res_cmp_d = 1'b0;
          res_ovr_d = 1'b0;
          st_d      = StEval;
        end
      end
      StEval: begin
        if (rem_q <= tba_pkg::RemW'(1)) begin
          res_cmp_d = 1'b1;
          st_d      = StFin;
        end else if (round_q >= tba_pkg::RoundW'(tba_pkg::MaxRounds)) begin
          res_ovr_d = 1'b1;
          st_d      = StFin;
        end else begin
          rd_en = 1'b1;
          st_d  = StChk;
        end
      end
      StChk: begin
        if ((odd_last && tkt == phase_q) || (!odd_last && tkt == claim_ph)) begin
          wr.en   = 1'b1;
          wr.data = done_ph;
          rem_d   = tba_pkg::RemW'(round_nodes);
          slot_d  = slot_q >> 1;
          probe_d = '0;
          round_d = round_q + tba_pkg::RoundW'(1);
          st_d    = StEval;
        end else if (!odd_last && tkt == phase_q) begin
          wr.en   = 1'b1;
          wr.data = claim_ph;
          st_d    = StFin;
        end else if (32'(probe_q) + 32'd1 >= 32'(round_nodes)) begin
          res_ovr_d = 1'b1;
          st_d      = StFin;
        end else begin
          slot_d  = (32'(slot_q) + 32'd1 >= 32'(round_nodes)) ? '0 :
                    slot_q + tba_pkg::CntW'(1);
          probe_d = probe_q + tba_pkg::CntW'(1);
          st_d    = StEval;
        end
      end
      StFin: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_cmp_d = res_cmp_q;
          out_ovr_d = res_ovr_q;
          st_d      = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      part_q    <= tba_pkg::PartW'(64);
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) begin
        part_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    slot_q    <= slot_d;
    probe_q   <= probe_d;
    round_q   <= round_d;
    phase_q   <= phase_d;
    res_cmp_q <= res_cmp_d;
    res_ovr_q <= res_ovr_d;
    out_cmp_q <= out_cmp_d;
    out_ovr_q <= out_ovr_d;
  end

  `TBA_ASSERT_IMPL(a_slot_in_round, (st_q == StChk), (slot_q < round_nodes))
  `TBA_ASSERT_IMPL(a_wr_step, wr.en, (wr.data == claim_ph || wr.data == done_ph))
  `TBA_ASSERT_NEVER(a_res_excl, (out_vld_q && out_cmp_q && out_ovr_q))
  `TBA_ASSERT_IMPL(a_wr_after_rd, wr.en, (st_q == StChk && $past(rd_en)))

endmodule
